### src/bet_pkg.sv
// Package: shared types and constants for the button edge and auto-repeat tracker.
`timescale 1ns / 1ps

package bet_pkg;

    localparam int BUTTON_W             = 8;
    localparam int DEFAULT_BUTTON_COUNT = 8;
    localparam int CFG_INDEX_W          = 8;
    localparam int IN_TDATA_W           = 24;
    localparam int OUT_TDATA_W          = 64;

    localparam logic [BUTTON_W-1:0] INITIAL_DELAY_RST = 8'd16;
    localparam logic [BUTTON_W-1:0] REPEAT_RATE_RST   = 8'd4;

    typedef enum logic
    {
        CMD_SAMPLE = 1'b0,
        CMD_CLEAR  = 1'b1
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        CFG_INITIAL_DELAY = 8'd0,
        CFG_REPEAT_RATE   = 8'd1
    } cfg_index_t;

    typedef struct packed
    {
        logic [BUTTON_W-1:0] initial_delay;
        logic [BUTTON_W-1:0] repeat_rate;
    } cfg_t;

    typedef struct packed
    {
        cmd_t                cmd;
        logic [BUTTON_W-1:0] secondary_combo;
        logic [BUTTON_W-1:0] primary_combo;
        logic [BUTTON_W-1:0] buttons;
    } item_t;

    typedef struct packed
    {
        logic [BUTTON_W-1:0] last_sample;
        logic [BUTTON_W-1:0] new_press;
        logic [BUTTON_W-1:0] repeat_press;
        logic [BUTTON_W-1:0] release_bits;
        logic [BUTTON_W-1:0] countdown;
        logic [BUTTON_W-1:0] held_or;
        logic [BUTTON_W-1:0] new_or;
        logic [BUTTON_W-1:0] repeat_or;
    } track_state_t;

    typedef struct packed
    {
        logic combo_pressed;
        logic combo_held;
    } combo_flags_t;

endpackage

### src/button_edge_autorepeat_tracker.sv
// Top level: input register, frame state, result register and configuration.
`timescale 1ns / 1ps

// Button edge detector with auto-repeat, sticky accumulators and combo tests.
// Input stream s_axis_*: one item per transfer; tuser carries the command
// (sample frame or clear accumulators), tdata the button vector and two combos.
// Output stream m_axis_*: exactly one result per input item, in order.
// Config channel cfg_*: index 0 is initial_delay, index 1 repeat_rate; always
// ready. Write it only while no item is in flight.
// The input transfer loads the input register, the result register is loaded
// from it, and the result is offered from the result register. Throughput:
// one item per cycle while the receiver does not stall; the frame state is
// updated in the same cycle that moves an item from input to result register,
// so consecutive items chain without a gap.
// When the receiver stalls, the result register holds and the input register
// fills; s_axis_tready drops only once both are occupied.
// Reset clears all frame state and accumulators, sets initial_delay to 16 and
// repeat_rate to 4, and empties both pipeline registers.

module button_edge_autorepeat_tracker
#(
    parameter int BUTTON_COUNT = bet_pkg::DEFAULT_BUTTON_COUNT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] buttons, [15:8] primary_combo, [23:16] secondary_combo
    input  logic [bet_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] cmd
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] held_now, [15:8] new_presses, [23:16] repeat_presses,
    // [31:24] releases, [39:32] held_accum, [47:40] new_accum,
    // [55:48] repeat_accum, [56] combo_pressed, [57] combo_held, [63:58] zero
    output logic [bet_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bet_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bet_pkg::BUTTON_W-1:0]    cfg_data
);
    import bet_pkg::*;

    cfg_t                   cfg;
    item_t                  item_reg;
    logic                   in_valid_reg;
    logic                   in_valid_next;
    track_state_t           state_reg;
    track_state_t           state_next;
    combo_flags_t           flags;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   advance;
    logic                   in_xfer;

    assign cfg_ready = 1'b1;

    bet_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bet_step #(.BUTTON_COUNT(BUTTON_COUNT)) u_step
    (
        .item       (item_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next),
        .flags      (flags)
    );

    // result register free or being drained this cycle
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = in_xfer || (in_valid_reg && !advance);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    assign out_data_next = {6'b0, flags.combo_held, flags.combo_pressed,
                            state_next.repeat_or, state_next.new_or,
                            state_next.held_or, state_next.release_bits,
                            state_next.repeat_press, state_next.new_press,
                            state_next.last_sample};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance && in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= item_t'({s_axis_tuser, s_axis_tdata});
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### src/bet_cfg_regs.sv
// Configuration registers: initial delay and repeat rate.
`timescale 1ns / 1ps

module bet_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [bet_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [bet_pkg::BUTTON_W-1:0]    wr_data,
    output bet_pkg::cfg_t                   cfg
);
    import bet_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_INITIAL_DELAY: cfg_next.initial_delay = wr_data;
                CFG_REPEAT_RATE:   cfg_next.repeat_rate   = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_delay <= INITIAL_DELAY_RST;
            cfg_reg.repeat_rate   <= REPEAT_RATE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/bet_step.sv
// Per-frame step: edges, auto-repeat countdown, accumulators and combo tests.
`timescale 1ns / 1ps

module bet_step
#(
    parameter int BUTTON_COUNT = bet_pkg::DEFAULT_BUTTON_COUNT
)
(
    input  bet_pkg::item_t        item,
    input  bet_pkg::cfg_t         cfg,
    input  bet_pkg::track_state_t state,
    output bet_pkg::track_state_t state_next,
    output bet_pkg::combo_flags_t flags
);
    import bet_pkg::*;

    localparam logic [BUTTON_W-1:0] BTN_MASK = (BUTTON_COUNT >= BUTTON_W) ?
        {BUTTON_W{1'b1}} : BUTTON_W'((64'd1 << BUTTON_COUNT) - 64'd1);

    logic [BUTTON_W-1:0] cur;
    logic [BUTTON_W-1:0] prim;
    logic [BUTTON_W-1:0] sec;
    logic [BUTTON_W-1:0] diff;
    logic [BUTTON_W-1:0] count_dec;
    logic [BUTTON_W-1:0] np;
    logic                prim_full;
    logic                sec_full;

    assign cur       = item.buttons & BTN_MASK;
    assign prim      = item.primary_combo & BTN_MASK;
    assign sec       = item.secondary_combo & BTN_MASK;
    assign diff      = cur ^ state.last_sample;
    assign count_dec = state.countdown - BUTTON_W'(1);

    always_comb
    begin
        state_next = state;
        unique case (item.cmd)
            CMD_CLEAR:
            begin
                state_next.held_or   = '0;
                state_next.new_or    = '0;
                state_next.repeat_or = '0;
            end
            CMD_SAMPLE:
            begin
                state_next.new_press    = diff & cur;
                state_next.repeat_press = diff & cur;
                state_next.release_bits = diff & state.last_sample;
                if (cur != '0 && cur == state.last_sample)
                begin
                    // unchanged non-empty set: run the countdown, reissue on expiry
                    state_next.countdown = count_dec;
                    if (count_dec == '0)
                    begin
                        state_next.repeat_press = cur;
                        state_next.countdown    = cfg.repeat_rate;
                    end
                end
                else
                begin
                    state_next.countdown = cfg.initial_delay;
                end
                state_next.last_sample = cur;
                state_next.held_or     = state.held_or | cur;
                state_next.new_or      = state.new_or | (diff & cur);
                state_next.repeat_or   = state.repeat_or | state_next.repeat_press;
            end
            default: state_next = state;
        endcase
    end

    // combos are tested against the frame state after this item
    assign np        = state_next.new_press;
    assign prim_full = (prim != '0) && ((state_next.last_sample & prim) == prim);
    assign sec_full  = (sec != '0) && ((state_next.last_sample & sec) == sec);

    assign flags.combo_held    = prim_full || sec_full;
    assign flags.combo_pressed = (prim_full && ((np & prim) != '0)) ||
                                 (sec_full && ((np & sec) != '0));

endmodule

### src/bet_checker.sv
// Port-level checker for the tracker, bound to the top level.
`timescale 1ns / 1ps

module bet_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bet_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import bet_pkg::*;

    logic [BUTTON_W-1:0] held_now;
    logic [BUTTON_W-1:0] new_presses;
    logic [BUTTON_W-1:0] repeat_presses;
    logic [BUTTON_W-1:0] releases;

    assign held_now       = m_axis_tdata[7:0];
    assign new_presses    = m_axis_tdata[15:8];
    assign repeat_presses = m_axis_tdata[23:16];
    assign releases       = m_axis_tdata[31:24];

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready with empty output");

    a_edge_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((new_presses & releases) == '0) &&
                          ((new_presses & held_now) == new_presses) &&
                          ((repeat_presses & held_now) == repeat_presses) &&
                          ((releases & held_now) == '0))
        else $error("press and release vectors inconsistent with held set");

    a_combo_implies: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[56] |-> m_axis_tdata[57])
        else $error("combo pressed without combo held");

endmodule

bind button_edge_autorepeat_tracker bet_checker u_bet_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### verif/button_edge_tracker_checker.sv
// Checker: watches all three channels, predicts each frame result and compares it.
`timescale 1ns / 1ps

module button_edge_tracker_checker
#(
    parameter int BUTTON_COUNT = bet_pkg::DEFAULT_BUTTON_COUNT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // [7:0] buttons, [15:8] primary_combo, [23:16] secondary_combo
    input  logic [bet_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] cmd
    input  logic                            s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] held_now, [15:8] new_presses, [23:16] repeat_presses,
    // [31:24] releases, [39:32] held_accum, [47:40] new_accum,
    // [55:48] repeat_accum, [56] combo_pressed, [57] combo_held, [63:58] zero
    input  logic [bet_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [bet_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bet_pkg::BUTTON_W-1:0]    cfg_data,
    output int                              mismatch_count,
    output int                              outstanding
);

    localparam logic [7:0] BUTTON_MASK = 8'((64'd1 << BUTTON_COUNT) - 64'd1);

    typedef struct packed
    {
        logic [5:0] pad;
        logic       combo_held;
        logic       combo_pressed;
        logic [7:0] repeat_accum;
        logic [7:0] new_accum;
        logic [7:0] held_accum;
        logic [7:0] releases;
        logic [7:0] repeat_presses;
        logic [7:0] new_presses;
        logic [7:0] held_now;
    } frame_result_t;

    frame_result_t expected_frames[$];

    logic [7:0] init_delay;
    logic [7:0] rep_rate;
    logic [7:0] prev_buttons;
    logic [7:0] press_bits;
    logic [7:0] autorep_bits;
    logic [7:0] release_bits;
    logic [7:0] countdown;
    logic [7:0] held_acc;
    logic [7:0] press_acc;
    logic [7:0] autorep_acc;

    initial
    begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    function automatic frame_result_t track_item(bet_pkg::item_t it);
        logic [7:0]    cur;
        logic [7:0]    pc;
        logic [7:0]    sc;
        logic [7:0]    diff;
        logic          p_full;
        logic          s_full;
        frame_result_t r;
        cur = it.buttons & BUTTON_MASK;
        pc  = it.primary_combo & BUTTON_MASK;
        sc  = it.secondary_combo & BUTTON_MASK;
        if (it.cmd == bet_pkg::CMD_CLEAR)
        begin
            // clear touches the accumulators only
            held_acc    = '0;
            press_acc   = '0;
            autorep_acc = '0;
        end
        else
        begin
            diff         = cur ^ prev_buttons;
            press_bits   = diff & cur;
            autorep_bits = press_bits;
            release_bits = diff & prev_buttons;
            if (cur != '0 && cur == prev_buttons)
            begin
                countdown = countdown - 8'd1;
                if (countdown == '0)
                begin
                    autorep_bits = cur;
                    countdown    = rep_rate;
                end
            end
            else
            begin
                countdown = init_delay;
            end
            prev_buttons = cur;
            held_acc     = held_acc | cur;
            press_acc    = press_acc | press_bits;
            autorep_acc  = autorep_acc | autorep_bits;
        end
        p_full = pc != '0 && (prev_buttons & pc) == pc;
        s_full = sc != '0 && (prev_buttons & sc) == sc;
        r                = '0;
        r.held_now       = prev_buttons;
        r.new_presses    = press_bits;
        r.repeat_presses = autorep_bits;
        r.releases       = release_bits;
        r.held_accum     = held_acc;
        r.new_accum      = press_acc;
        r.repeat_accum   = autorep_acc;
        r.combo_held     = p_full || s_full;
        r.combo_pressed  = (p_full && (press_bits & pc) != '0) ||
                           (s_full && (press_bits & sc) != '0);
        return r;
    endfunction

    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            if (mismatch_count < 10)
                $display("%0t: %s expected %02h, got %02h", $realtime, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t want;
        frame_result_t got;
        if (!rst_n)
        begin
            init_delay   = bet_pkg::INITIAL_DELAY_RST;
            rep_rate     = bet_pkg::REPEAT_RATE_RST;
            prev_buttons = '0;
            press_bits   = '0;
            autorep_bits = '0;
            release_bits = '0;
            countdown    = '0;
            held_acc     = '0;
            press_acc    = '0;
            autorep_acc  = '0;
            expected_frames.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bet_pkg::CFG_INITIAL_DELAY: init_delay = cfg_data;
                    bet_pkg::CFG_REPEAT_RATE:   rep_rate   = cfg_data;
                    default: ;
                endcase
            end
            // retire the oldest expectation before queuing this edge's input
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = frame_result_t'(m_axis_tdata);
                if (expected_frames.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: result %016h with nothing expected",
                                 $realtime, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    compare_field("held_now", want.held_now, got.held_now);
                    compare_field("new_presses", want.new_presses, got.new_presses);
                    compare_field("repeat_presses", want.repeat_presses, got.repeat_presses);
                    compare_field("releases", want.releases, got.releases);
                    compare_field("held_accum", want.held_accum, got.held_accum);
                    compare_field("new_accum", want.new_accum, got.new_accum);
                    compare_field("repeat_accum", want.repeat_accum, got.repeat_accum);
                    compare_field("combo_pressed", 8'(want.combo_pressed),
                                  8'(got.combo_pressed));
                    compare_field("combo_held", 8'(want.combo_held), 8'(got.combo_held));
                    compare_field("pad", 8'(want.pad), 8'(got.pad));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_frames.push_back(
                    track_item(bet_pkg::item_t'({s_axis_tuser, s_axis_tdata})));
            outstanding <= expected_frames.size();
        end
    end

endmodule

### verif/testbench.sv
// Testbench top: clock, reset, frame stimulus, receiver back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;

    import bet_pkg::*;

    localparam int PHASE_ITEMS = 275;
    localparam int PHASES      = 6;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [BUTTON_W-1:0]    cfg_data;
    int                     mismatch_count;
    int                     outstanding;
    bit                     steady_phase = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    button_edge_autorepeat_tracker dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    button_edge_tracker_checker checker_inst
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    task automatic send_frame(cmd_t cmd, logic [7:0] buttons, logic [7:0] pc,
                              logic [7:0] sc);
        while (!steady_phase && $urandom_range(99) < 34)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {sc, pc, buttons};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and hold until every frame result has come back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_combo(logic [7:0] buttons);
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return buttons & 8'($urandom);
            2:       return buttons;
            default: return 8'($urandom);
        endcase
    endfunction

    // Receiver: random back-pressure, one long hold-off once results are flowing.
    initial
    begin : receiver
        int transfers;
        int hold_left;
        bit held_off;
        transfers     = 0;
        hold_left     = 0;
        held_off      = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                transfers++;
            if (!held_off && transfers >= 150)
            begin
                held_off  = 1'b1;
                hold_left = 200;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= steady_phase || $urandom_range(99) >= 34;
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0] delay;
        logic [7:0] rate;
        logic [7:0] held;
        logic [7:0] buttons;
        cmd_t       cmd;
        int         run_len;
        int         sent;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: empty frame, full press, hold, clear, release, change
        send_frame(CMD_SAMPLE, 8'h00, 8'h00, 8'h00);
        send_frame(CMD_SAMPLE, 8'hFF, 8'hFF, 8'h00);
        send_frame(CMD_SAMPLE, 8'hFF, 8'h0F, 8'hF0);
        send_frame(CMD_CLEAR,  8'hAA, 8'hFF, 8'h00);
        send_frame(CMD_SAMPLE, 8'h0F, 8'h01, 8'h80);
        send_frame(CMD_SAMPLE, 8'hF0, 8'h80, 8'h81);
        send_frame(CMD_SAMPLE, 8'h00, 8'hFF, 8'hFF);
        send_frame(CMD_CLEAR,  8'hFF, 8'h00, 8'h00);
        // shortest delays: repeat on every held frame
        wait_idle();
        write_reg(CFG_INITIAL_DELAY, 8'd1);
        write_reg(CFG_REPEAT_RATE, 8'd1);
        repeat (4) send_frame(CMD_SAMPLE, 8'h55, 8'h05, 8'h00);
        wait_idle();
        write_reg(CFG_INITIAL_DELAY, 8'd2);
        write_reg(CFG_REPEAT_RATE, 8'd255);
        repeat (4) send_frame(CMD_SAMPLE, 8'h3C, 8'h00, 8'h3C);
        send_frame(CMD_SAMPLE, 8'h3D, 8'h01, 8'h3C);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0:       begin delay = INITIAL_DELAY_RST; rate = REPEAT_RATE_RST; end
                1:       begin delay = 8'd1;   rate = 8'd1;   end
                2:       begin delay = 8'd255; rate = 8'd255; end
                default:
                begin
                    delay = 8'($urandom_range(1, 255));
                    rate  = 8'($urandom_range(1, 255));
                end
            endcase
            write_reg(CFG_INITIAL_DELAY, delay);
            write_reg(CFG_REPEAT_RATE, rate);
            steady_phase = (ph == 3);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // mostly held runs of one button set, some long enough to repeat
                held = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom);
                if ($urandom_range(99) < 15)
                    run_len = delay + rate * $urandom_range(2) + $urandom_range(2);
                else
                    run_len = $urandom_range(1, 12);
                for (int k = 0; k < run_len && sent < PHASE_ITEMS; k++)
                begin
                    cmd     = ($urandom_range(99) < 4) ? CMD_CLEAR : CMD_SAMPLE;
                    buttons = ($urandom_range(99) < 3 || cmd == CMD_CLEAR)
                              ? 8'($urandom) : held;
                    send_frame(cmd, buttons, pick_combo(held), pick_combo(held));
                    sent++;
                end
            end
        end
        steady_phase = 1'b0;

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
src/bet_pkg.sv
src/bet_cfg_regs.sv
src/bet_step.sv
src/button_edge_autorepeat_tracker.sv
src/bet_checker.sv
verif/button_edge_tracker_checker.sv
verif/testbench.sv
